// ===== src/pcdc_pkg.sv =====
`timescale 1ns / 1ps

package pcdc_pkg;

    localparam int CMD_W    = 2;
    localparam int BRIGHT_W = 8;
    localparam int LEVEL_W  = 6;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int TAB_SLOTS  = 32;
    localparam int TAB_IDX_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 2'd2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PULSE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OFF   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMMING_LEVEL  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS = 8'd1;

    localparam logic [LEVEL_W-1:0]  LEVEL_WRAP      = 6'd32;
    localparam logic [LEVEL_W-1:0]  LEVEL_OFF       = 6'd0;
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL     = 8'd255;
    localparam logic [BRIGHT_W-1:0] BRIGHT_ZERO     = 8'd0;
    localparam logic [LEVEL_W-1:0]  RST_DIMMING_LVL = 6'd32;
    localparam logic [BRIGHT_W-1:0] RST_MIN_BRIGHT  = 8'd20;
    localparam logic [LEVEL_W-1:0]  RST_HELD_LEVEL  = 6'd1;

    // Threshold / level table, padded to 32 slots
    localparam logic [BRIGHT_W-1:0] THR_TAB [0:TAB_SLOTS-1] = '{
        8'd20,  8'd31,  8'd42,  8'd53,  8'd64,  8'd76,  8'd88,  8'd100,
        8'd112, 8'd124, 8'd136, 8'd148, 8'd160, 8'd166, 8'd172, 8'd178,
        8'd184, 8'd190, 8'd196, 8'd202, 8'd208, 8'd214, 8'd220, 8'd226,
        8'd232, 8'd238, 8'd244, 8'd250, 8'd255, 8'd255, 8'd255, 8'd255
    };
    localparam logic [LEVEL_W-1:0] LVL_TAB [0:TAB_SLOTS-1] = '{
        6'd32, 6'd31, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25,
        6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17,
        6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,
        6'd8,  6'd7,  6'd6,  6'd5,  6'd4,  6'd4,  6'd4,  6'd4
    };

    typedef struct packed {
        logic [LEVEL_W-1:0]  dimming_level;
        logic [BRIGHT_W-1:0] min_brightness;
    } t_map_cfg;

endpackage

// ===== src/pcdc_if.sv =====
`timescale 1ns / 1ps

interface pcdc_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [pcdc_pkg::CMD_W-1:0]     cmd;
    logic [pcdc_pkg::BRIGHT_W-1:0]  brightness;

    modport source (output valid, output cmd, output brightness, input ready);
    modport sink   (input valid, input cmd, input brightness, output ready);
endinterface

interface pcdc_res_if;
    logic                           valid;
    logic                           ready;
    logic [pcdc_pkg::ACTION_W-1:0]  action;
    logic [pcdc_pkg::LEVEL_W-1:0]   pulse_count;
    logic [pcdc_pkg::LEVEL_W-1:0]   level_now;

    modport source (output valid, output action, output pulse_count, output level_now,
                    input ready);
    modport sink   (input valid, input action, input pulse_count, input level_now,
                    output ready);
endinterface

interface pcdc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pcdc_pkg::CFG_IDX_W-1:0]   addr;
    logic [pcdc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== src/pcdc_level_map.sv =====
`timescale 1ns / 1ps

module pcdc_level_map #(
    parameter int TABLE_ENTRIES = 29
) (
    input  logic [pcdc_pkg::BRIGHT_W-1:0] i_brightness,
    input  pcdc_pkg::t_map_cfg            i_cfg,
    output logic [pcdc_pkg::LEVEL_W-1:0]  o_level
);
    import pcdc_pkg::*;

    localparam logic [TAB_IDX_W-1:0] LAST_IDX = TAB_IDX_W'(TABLE_ENTRIES - 1);

    logic [LEVEL_W-1:0] w_tab_level;
    logic [LEVEL_W-1:0] w_dim_level;

    // first threshold at or above the brightness; saturate to last entry
    always_comb begin
        w_tab_level = LVL_TAB[LAST_IDX];
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (i_brightness <= THR_TAB[i[TAB_IDX_W-1:0]]) begin
                w_tab_level = LVL_TAB[i[TAB_IDX_W-1:0]];
            end
        end
    end

    assign w_dim_level = (i_cfg.dimming_level > LEVEL_WRAP) ? LEVEL_WRAP
                                                            : i_cfg.dimming_level;

    always_comb begin
        if (i_brightness == BRIGHT_ZERO) begin
            o_level = LEVEL_OFF;
        end else if (i_brightness < i_cfg.min_brightness) begin
            o_level = w_dim_level;
        end else if (i_brightness == BRIGHT_FULL) begin
            o_level = LVL_TAB[LAST_IDX];
        end else begin
            o_level = w_tab_level;
        end
    end

endmodule

// ===== src/pulse_count_dimming_controller_top.sv =====
`timescale 1ns / 1ps

// Pulse-count dimming controller for a one-wire LED driver.
//
// i_cmd : command beats (cmd, brightness). Set brightness, suspend or resume.
// o_res : one result beat per command: action (nothing / send pulses / off),
//         pulse_count and the driver level held afterwards.
// i_cfg : register writes (addr 0 dimming level, addr 1 minimum brightness);
//         always ready, write only while no command is in flight.
//
// A beat taken from i_cmd is registered in the input register, mapped to a
// level and compared with the held level, and its result is then written
// into the output register. Throughput is one beat per cycle while o_res
// does not stall, set by the combinational level map and forward-difference
// path between the two registers.
// When o_res stalls, the output register holds its beat and the input
// register fills; i_cmd.ready drops only while both are full.
// Reset (i_rst_n low, synchronous) empties both stages, restores the
// registers to dimming level 32 and minimum 20, and marks the driver awake
// at level 1 with last brightness 0.

module pulse_count_dimming_controller_top #(
    parameter int TABLE_ENTRIES = 29
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcdc_cmd_if.sink    i_cmd,
    pcdc_res_if.source  o_res,
    pcdc_cfg_if.sink    i_cfg
);
    import pcdc_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0]  r_dim_level;
    logic [BRIGHT_W-1:0] r_min_bright;

    // driver state
    logic [LEVEL_W-1:0]  r_held, n_held;
    logic                r_awake, n_awake;
    logic [BRIGHT_W-1:0] r_last, n_last;

    // input stage
    logic                r_s1_valid;
    logic [CMD_W-1:0]    r_s1_cmd;
    logic [BRIGHT_W-1:0] r_s1_bright;

    // result stage
    logic                r_out_valid;
    logic [ACTION_W-1:0] r_out_action, n_out_action;
    logic [LEVEL_W-1:0]  r_out_pulses, n_out_pulses;
    logic [LEVEL_W-1:0]  r_out_level;

    logic                w_adv;
    logic                w_take;
    logic [BRIGHT_W-1:0] w_apply_b;
    logic [LEVEL_W-1:0]  w_target;
    logic [LEVEL_W:0]    w_fwd;
    t_map_cfg            w_map_cfg;

    // result register frees up when empty or being drained
    assign w_adv  = r_s1_valid && (!r_out_valid || o_res.ready);
    assign w_take = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_s1_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_out_action;
    assign o_res.pulse_count = r_out_pulses;
    assign o_res.level_now   = r_out_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_level  <= RST_DIMMING_LVL;
            r_min_bright <= RST_MIN_BRIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                REG_DIMMING_LEVEL:  r_dim_level  <= i_cfg.data[LEVEL_W-1:0];
                REG_MIN_BRIGHTNESS: r_min_bright <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_cmd    <= i_cmd.cmd;
            r_s1_bright <= i_cmd.brightness;
        end
    end

    // resume replays the last requested brightness
    assign w_apply_b = (r_s1_cmd == CMD_SET) ? r_s1_bright : r_last;

    assign w_map_cfg.dimming_level  = r_dim_level;
    assign w_map_cfg.min_brightness = r_min_bright;

    pcdc_level_map #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_map (
        .i_brightness (w_apply_b),
        .i_cfg        (w_map_cfg),
        .o_level      (w_target)
    );

    // forward distance around the 32-level ring, 1..32 when levels differ and the target is not off
    assign w_fwd = (r_held <= w_target)
                 ? ({1'b0, w_target} - {1'b0, r_held})
                 : ({1'b0, LEVEL_WRAP} - ({1'b0, r_held} - {1'b0, w_target}));

    always_comb begin
        n_held       = r_held;
        n_awake      = r_awake;
        n_last       = r_last;
        n_out_action = ACT_NONE;
        n_out_pulses = '0;
        case (r_s1_cmd)
            CMD_SET: begin
                n_last = r_s1_bright;
                if (r_awake && (w_target != r_held)) begin
                    n_held = w_target;
                    if (w_target == LEVEL_OFF) begin
                        n_out_action = ACT_OFF;
                    end else begin
                        n_out_action = ACT_PULSE;
                        n_out_pulses = w_fwd[LEVEL_W-1:0];
                    end
                end
            end
            CMD_SUSPEND: begin
                n_awake      = 1'b0;
                n_held       = LEVEL_OFF;
                n_out_action = ACT_OFF;
            end
            CMD_RESUME: begin
                n_awake = 1'b1;
                if (w_target != r_held) begin
                    n_held = w_target;
                    if (w_target == LEVEL_OFF) begin
                        n_out_action = ACT_OFF;
                    end else begin
                        n_out_action = ACT_PULSE;
                        n_out_pulses = w_fwd[LEVEL_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= RST_HELD_LEVEL;
            r_awake     <= 1'b1;
            r_last      <= BRIGHT_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_held      <= n_held;
                r_awake     <= n_awake;
                r_last      <= n_last;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_action <= n_out_action;
            r_out_pulses <= n_out_pulses;
            r_out_level  <= n_held;
        end
    end

endmodule
